/* rtl/pci_pkg.sv */
// ----------------------------------------------------------------------------
// pci_pkg: shared types and helpers for the particle contact impulse pipeline
// Request and response payloads, outcome codes, per-stage work record and the
// fixed-point rounding and saturation helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package pci_pkg;

   localparam int DIV_BITS = 57;
   localparam logic [56:0] SAT_LIM = 57'(1) << 56;
   localparam logic [17:0] ONE_Q16 = 18'd65536;
   localparam logic signed [57:0] S32_MAX = 58'sd2147483647;
   localparam logic signed [57:0] S32_MIN = -58'sd2147483648;

   typedef enum logic [1:0] {
      OUT_SEPARATING = 2'd0,
      OUT_NO_MASS    = 2'd1,
      OUT_APPLIED    = 2'd2
   } outcome_type;

   typedef struct packed {
      logic [31:0] first_vel_x;
      logic [31:0] first_vel_y;
      logic [31:0] first_vel_z;
      logic [31:0] second_vel_x;
      logic [31:0] second_vel_y;
      logic [31:0] second_vel_z;
      logic [30:0] first_inv_mass;
      logic [30:0] second_inv_mass;
      logic [16:0] restitution;
      logic [31:0] normal_x;
      logic [31:0] normal_y;
      logic [31:0] normal_z;
   } req_type;

   typedef struct packed {
      logic [31:0] new_first_x;
      logic [31:0] new_first_y;
      logic [31:0] new_first_z;
      logic [31:0] new_second_x;
      logic [31:0] new_second_y;
      logic [31:0] new_second_z;
      outcome_type outcome;
   } rsp_type;

   typedef struct packed {
      req_type               req;
      logic [2:0][32:0]      diff;
      logic [2:0][48:0]      prod;
      logic [50:0]           vs;
      logic [31:0]           tim;
      outcome_type           outcome;
      logic [49:0]           mag_m;
      logic [51:0]           delta;
      logic [31:0]           rem;
      logic [56:0]           quo;
      logic                  qsat;
      logic [56:0]           imp;
      logic [2:0][56:0]      pp_hi;
      logic [2:0][63:0]      pp_lo;
      logic [2:0]            p_neg;
      logic [2:0][56:0]      p_mag;
      logic [1:0][2:0][55:0] pq_hi;
      logic [1:0][2:0][62:0] pq_lo;
      logic [1:0][2:0][56:0] chg;
      rsp_type               res;
   } work_type;

   function automatic logic [2:0][31:0] vel1(input req_type r);
      return {r.first_vel_z, r.first_vel_y, r.first_vel_x};
   endfunction

   function automatic logic [2:0][31:0] vel2(input req_type r);
      return {r.second_vel_z, r.second_vel_y, r.second_vel_x};
   endfunction

   function automatic logic [2:0][31:0] norm(input req_type r);
      return {r.normal_z, r.normal_y, r.normal_x};
   endfunction

   // magnitude of a product shifted by 16, rounded away from zero when negative
   function automatic logic [56:0] q16_round(input logic [88:0] total, input logic neg);
      logic inc;
      inc = neg && (total[15:0] != 16'd0);
      if (total[88:64] != 25'd0) begin
         return SAT_LIM;
      end
      return 57'(total[63:16]) + 57'(inc);
   endfunction

   function automatic logic [31:0] sat32(input logic signed [57:0] v);
      if (v > S32_MAX) begin
         return 32'h7fff_ffff;
      end
      if (v < S32_MIN) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

endpackage

`default_nettype wire

/* rtl/particle_contact_impulse_top.sv */
// ----------------------------------------------------------------------------
// particle_contact_impulse_top: impulse resolution of one particle contact
// Requests enter on req_valid/req_stall/req_data, one contact each: two
// velocities, two inverse masses, restitution and contact normal. Each request
// gives exactly one response on rsp_valid/rsp_stall/rsp_data with the new
// velocities and an outcome code (separating, no movable mass, applied).
// One request is taken every cycle while the pipeline is not held; the
// pipeline has 70 stages, of which 57 are the one-bit-per-stage impulse
// divider. When a response is held by rsp_stall the whole pipeline holds
// and req_stall rises in the same cycle; nothing is dropped or repeated.
// Synchronous reset clears all stage valid bits; no response is pending
// after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_contact_impulse_top
   import pci_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   localparam int ST_CAP     = 0;
   localparam int ST_DIFF    = 1;
   localparam int ST_PROD    = 2;
   localparam int ST_SUM     = 3;
   localparam int ST_CLASS   = 4;
   localparam int ST_DELTA   = 5;
   localparam int ST_DIVI    = 6;
   localparam int ST_DIV0    = 7;
   localparam int ST_IMP     = ST_DIV0 + DIV_BITS;
   localparam int ST_PP1     = ST_IMP + 1;
   localparam int ST_P       = ST_IMP + 2;
   localparam int ST_PP2     = ST_IMP + 3;
   localparam int ST_CHG     = ST_IMP + 4;
   localparam int ST_OUT     = ST_IMP + 5;
   localparam int NUM_STAGES = ST_OUT + 1;

   work_type st_ff [NUM_STAGES];
   work_type st_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic adv;

   assign adv       = !(vld_ff[ST_OUT] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = vld_ff[ST_OUT];
   assign rsp_data  = st_ff[ST_OUT].res;
   assign vld_in    = {vld_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      st_in[ST_CAP]     = '0;
      st_in[ST_CAP].req = req_data;
   end

   always_comb begin : c_diff
      logic [2:0][31:0] v1;
      logic [2:0][31:0] v2;
      st_in[ST_DIFF] = st_ff[ST_DIFF-1];
      v1 = vel1(st_ff[ST_DIFF-1].req);
      v2 = vel2(st_ff[ST_DIFF-1].req);
      for (int a = 0; a < 3; a++) begin
         st_in[ST_DIFF].diff[a] = {v1[a][31], v1[a]} - {v2[a][31], v2[a]};
      end
   end

   always_comb begin : c_prod
      logic [2:0][31:0] nv;
      logic signed [64:0] pr;
      st_in[ST_PROD] = st_ff[ST_PROD-1];
      nv = norm(st_ff[ST_PROD-1].req);
      for (int a = 0; a < 3; a++) begin
         pr = 65'($signed(st_ff[ST_PROD-1].diff[a])) * 65'($signed(nv[a]));
         st_in[ST_PROD].prod[a] = pr[64:16];
      end
   end

   always_comb begin : c_sum
      work_type w;
      w = st_ff[ST_SUM-1];
      st_in[ST_SUM] = w;
      st_in[ST_SUM].vs = {{2{w.prod[0][48]}}, w.prod[0]} + {{2{w.prod[1][48]}}, w.prod[1]}
                       + {{2{w.prod[2][48]}}, w.prod[2]};
      st_in[ST_SUM].tim = {1'b0, w.req.first_inv_mass} + {1'b0, w.req.second_inv_mass};
   end

   always_comb begin : c_class
      logic [50:0] neg_vs;
      work_type w;
      w = st_ff[ST_CLASS-1];
      neg_vs = 51'd0 - w.vs;
      st_in[ST_CLASS] = w;
      st_in[ST_CLASS].mag_m = neg_vs[49:0];
      if (!w.vs[50] && (w.vs != 51'd0)) begin
         st_in[ST_CLASS].outcome = OUT_SEPARATING;
      end else if (w.tim == 32'd0) begin
         st_in[ST_CLASS].outcome = OUT_NO_MASS;
      end else begin
         st_in[ST_CLASS].outcome = OUT_APPLIED;
      end
   end

   always_comb begin : c_delta
      logic [67:0] dp;
      work_type w;
      w = st_ff[ST_DELTA-1];
      dp = 68'(w.mag_m) * 68'(ONE_Q16 + 18'(w.req.restitution));
      st_in[ST_DELTA] = w;
      st_in[ST_DELTA].delta = dp[67:16];
   end

   always_comb begin : c_divi
      work_type w;
      w = st_ff[ST_DIVI-1];
      st_in[ST_DIVI] = w;
      st_in[ST_DIVI].rem  = 32'(w.delta[51:41]);
      st_in[ST_DIVI].qsat = 32'(w.delta[51:41]) >= w.tim;
      st_in[ST_DIVI].quo  = '0;
   end

   for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
      localparam int B = DIV_BITS - 1 - k;
      always_comb begin : c_step
         logic [67:0] dvd;
         logic [32:0] t;
         work_type w;
         w = st_ff[ST_DIV0+k-1];
         dvd = {w.delta, 16'd0};
         t = {w.rem, dvd[B]};
         st_in[ST_DIV0+k] = w;
         if (t >= {1'b0, w.tim}) begin
            st_in[ST_DIV0+k].rem    = 32'(t - {1'b0, w.tim});
            st_in[ST_DIV0+k].quo[B] = 1'b1;
         end else begin
            st_in[ST_DIV0+k].rem = t[31:0];
         end
      end
   end

   always_comb begin : c_imp
      work_type w;
      w = st_ff[ST_IMP-1];
      st_in[ST_IMP] = w;
      st_in[ST_IMP].imp = (w.qsat || (w.quo > SAT_LIM)) ? SAT_LIM : w.quo;
   end

   always_comb begin : c_pp1
      logic [2:0][31:0] nv;
      logic [31:0] nmag;
      work_type w;
      w = st_ff[ST_PP1-1];
      nv = norm(w.req);
      st_in[ST_PP1] = w;
      for (int a = 0; a < 3; a++) begin
         nmag = nv[a][31] ? (32'd0 - nv[a]) : nv[a];
         st_in[ST_PP1].pp_hi[a] = 57'(w.imp[56:32]) * 57'(nmag);
         st_in[ST_PP1].pp_lo[a] = 64'(w.imp[31:0]) * 64'(nmag);
      end
   end

   always_comb begin : c_p
      logic [2:0][31:0] nv;
      work_type w;
      w = st_ff[ST_P-1];
      nv = norm(w.req);
      st_in[ST_P] = w;
      for (int a = 0; a < 3; a++) begin
         st_in[ST_P].p_neg[a] = nv[a][31];
         st_in[ST_P].p_mag[a] = q16_round({w.pp_hi[a], 32'd0} + 89'(w.pp_lo[a]), nv[a][31]);
      end
   end

   always_comb begin : c_pp2
      logic [30:0] im;
      work_type w;
      w = st_ff[ST_PP2-1];
      st_in[ST_PP2] = w;
      for (int s = 0; s < 2; s++) begin
         im = (s == 0) ? w.req.first_inv_mass : w.req.second_inv_mass;
         for (int a = 0; a < 3; a++) begin
            st_in[ST_PP2].pq_hi[s][a] = 56'(w.p_mag[a][56:32]) * 56'(im);
            st_in[ST_PP2].pq_lo[s][a] = 63'(w.p_mag[a][31:0]) * 63'(im);
         end
      end
   end

   always_comb begin : c_chg
      work_type w;
      w = st_ff[ST_CHG-1];
      st_in[ST_CHG] = w;
      for (int s = 0; s < 2; s++) begin
         for (int a = 0; a < 3; a++) begin
            st_in[ST_CHG].chg[s][a] =
               q16_round({1'b0, w.pq_hi[s][a], 32'd0} + 89'(w.pq_lo[s][a]), w.p_neg[a]);
         end
      end
   end

   always_comb begin : c_out
      logic [2:0][31:0] v1;
      logic [2:0][31:0] v2;
      logic [2:0][31:0] n1;
      logic [2:0][31:0] n2;
      logic signed [57:0] c1;
      logic signed [57:0] c2;
      work_type w;
      w = st_ff[ST_OUT-1];
      v1 = vel1(w.req);
      v2 = vel2(w.req);
      for (int a = 0; a < 3; a++) begin
         c1 = w.p_neg[a] ? -$signed(58'(w.chg[0][a])) : $signed(58'(w.chg[0][a]));
         c2 = w.p_neg[a] ? -$signed(58'(w.chg[1][a])) : $signed(58'(w.chg[1][a]));
         if (w.outcome == OUT_APPLIED) begin
            n1[a] = sat32(58'($signed(v1[a])) + c1);
            n2[a] = sat32(58'($signed(v2[a])) - c2);
         end else begin
            n1[a] = v1[a];
            n2[a] = v2[a];
         end
      end
      st_in[ST_OUT] = w;
      st_in[ST_OUT].res.new_first_x  = n1[0];
      st_in[ST_OUT].res.new_first_y  = n1[1];
      st_in[ST_OUT].res.new_first_z  = n1[2];
      st_in[ST_OUT].res.new_second_x = n2[0];
      st_in[ST_OUT].res.new_second_y = n2[1];
      st_in[ST_OUT].res.new_second_z = n2[2];
      st_in[ST_OUT].res.outcome      = w.outcome;
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline moved while stalled");

   a_outcome_kept: assert property (@(posedge clock) disable iff (reset)
      adv && vld_ff[ST_CLASS] |=> st_ff[ST_DELTA].outcome == $past(st_ff[ST_CLASS].outcome))
      else $error("outcome changed between stages");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_IMP-1] && !st_ff[ST_IMP-1].qsat && st_ff[ST_IMP-1].outcome == OUT_APPLIED
      |-> st_ff[ST_IMP-1].rem < st_ff[ST_IMP-1].tim)
      else $error("divider remainder out of range");

   a_mass_present: assert property (@(posedge clock) disable iff (reset)
      vld_ff[ST_IMP] && st_ff[ST_IMP].outcome == OUT_APPLIED |-> st_ff[ST_IMP].tim != 32'd0)
      else $error("impulse applied without movable mass");

endmodule

`default_nettype wire
